/* hdl/sdpaml_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpaml_pkg
// Types and constants shared by the audio media line parser modules.
// ----------------------------------------------------------------------------
package sdpaml_pkg;

  localparam logic [12:0] RATE_OK = 13'd8000;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_FMT_ERR = 1'b1;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_SLASH = 8'h2f;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_UP_Z  = 8'h5a;
  localparam logic [7:0] CHR_LO_A  = 8'h61;
  localparam logic [7:0] CHR_LO_Z  = 8'h7a;
  localparam logic [7:0] CHR_M     = 8'h6d;

  // length of the "m=audio" key
  localparam logic [2:0] KEY_LEN = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] media_port;
    logic [7:0]  rtp_pt;
    logic [12:0] clock_rate;
  } out_item_t;

  // byte handed from the input register to the parser
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } step_t;

  // result handed from the parser to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  function automatic logic [7:0] key_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h6d; // m
      3'd1:    c = 8'h3d; // =
      3'd2:    c = 8'h61; // a
      3'd3:    c = 8'h75; // u
      3'd4:    c = 8'h64; // d
      3'd5:    c = 8'h69; // i
      3'd6:    c = 8'h6f; // o
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

  function automatic logic is_proto_char(input logic [7:0] c);
    return (c == CHR_SPACE) || (c == CHR_SLASH) ||
           ((c >= CHR_UP_A) && (c <= CHR_UP_Z)) ||
           ((c >= CHR_LO_A) && (c <= CHR_LO_Z));
  endfunction

endpackage

/* hdl/sdpaml_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpaml_in_stage
// Input register. Holds one byte; it waits only when it is a last byte
// and the output register is still full and stalled.
// ----------------------------------------------------------------------------
module sdpaml_in_stage
  import sdpaml_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     out_full_i,
  output step_t    step_o
);

  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_item_q;
  logic     blocked;

  // a last byte needs room in the output register
  assign blocked    = s1_valid_q && s1_item_q.last_byte && out_full_i;
  assign in_stall_o = blocked;

  assign step_o.fire = s1_valid_q && !blocked;
  assign step_o.item = s1_item_q;

  always_comb begin
    s1_valid_d = blocked ? s1_valid_q : in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!blocked) begin
      s1_item_q <= in_item_i;
    end
  end

endmodule

/* hdl/sdpaml_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpaml_parser
// Per-byte state machine: key search, port and payload type digits, and
// the held values that are updated on a good packet.
// ----------------------------------------------------------------------------
module sdpaml_parser
  import sdpaml_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  step_t step_i,
  output res_t  res_o
);

  localparam logic [2:0] PH_SEARCH     = 3'd0;
  localparam logic [2:0] PH_SKIP_WS    = 3'd1;
  localparam logic [2:0] PH_PORT       = 3'd2;
  localparam logic [2:0] PH_SKIP_PROTO = 3'd3;
  localparam logic [2:0] PH_TYPE       = 3'd4;
  localparam logic [2:0] PH_DONE       = 3'd5;

  logic [2:0]  match_q, match_d;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] port_acc_q, port_acc_d;
  logic        port_nz_q, port_nz_d;
  logic [7:0]  type_acc_q, type_acc_d;
  logic        type_nz_q, type_nz_d;
  logic [15:0] held_port_q, held_port_d;
  logic [7:0]  held_type_q, held_type_d;
  logic [12:0] held_rate_q, held_rate_d;

  logic [7:0]  c;
  logic [2:0]  pos;
  logic [2:0]  ph;
  logic        taken;
  logic        ok;

  assign c = step_i.item.data_byte;

  always_comb begin
    match_d     = match_q;
    phase_d     = phase_q;
    port_acc_d  = port_acc_q;
    port_nz_d   = port_nz_q;
    type_acc_d  = type_acc_q;
    type_nz_d   = type_nz_q;
    held_port_d = held_port_q;
    held_type_d = held_type_q;
    held_rate_d = held_rate_q;
    pos         = match_q;
    ph          = phase_q;
    taken       = 1'b0;
    ok          = 1'b0;
    res_o       = '0;

    if (step_i.fire) begin
      case (phase_q)
        PH_SEARCH: begin
          if (c == CHR_NUL) begin
            phase_d = PH_DONE;
          end else begin
            if ((match_q < KEY_LEN) && (c == key_char(match_q))) begin
              pos = match_q + 3'd1;
            end else begin
              // 'm' only opens the key, so a mismatch restarts
              pos = (c == CHR_M) ? 3'd1 : 3'd0;
            end
            match_d = pos;
            if (pos == KEY_LEN) begin
              phase_d = PH_SKIP_WS;
            end
          end
        end
        PH_SKIP_WS, PH_PORT, PH_SKIP_PROTO, PH_TYPE: begin
          // a byte that ends one phase is tried by the next
          if (ph == PH_SKIP_WS) begin
            if ((c == CHR_SPACE) || (c == CHR_TAB)) begin
              taken = 1'b1;
            end else begin
              ph = PH_PORT;
            end
          end
          if (!taken && (ph == PH_PORT)) begin
            if (is_digit(c)) begin
              port_acc_d = (port_acc_q << 3) + (port_acc_q << 1) + {12'd0, c[3:0]};
              if (c != CHR_ZERO) begin
                port_nz_d = 1'b1;
              end
              phase_d = PH_PORT;
              taken   = 1'b1;
            end else begin
              ph = PH_SKIP_PROTO;
            end
          end
          if (!taken && (ph == PH_SKIP_PROTO)) begin
            if (is_proto_char(c)) begin
              phase_d = PH_SKIP_PROTO;
              taken   = 1'b1;
            end else begin
              ph = PH_TYPE;
            end
          end
          if (!taken && (ph == PH_TYPE)) begin
            if (is_digit(c)) begin
              type_acc_d = (type_acc_q << 3) + (type_acc_q << 1) + {4'd0, c[3:0]};
              if (c != CHR_ZERO) begin
                type_nz_d = 1'b1;
              end
              phase_d = PH_TYPE;
              taken   = 1'b1;
            end
          end
          if (!taken) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase

      if (step_i.item.last_byte) begin
        ok = port_nz_d && type_nz_d;
        if (ok) begin
          held_port_d = port_acc_d;
          held_type_d = type_acc_d;
          held_rate_d = RATE_OK;
        end
        res_o.valid           = 1'b1;
        res_o.item.status     = ok ? STATUS_OK : STATUS_FMT_ERR;
        res_o.item.media_port = held_port_d;
        res_o.item.rtp_pt     = held_type_d;
        res_o.item.clock_rate = held_rate_d;
        // packet boundary: per-packet state back to reset
        match_d    = 3'd0;
        phase_d    = PH_SEARCH;
        port_acc_d = '0;
        port_nz_d  = 1'b0;
        type_acc_d = '0;
        type_nz_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q     <= 3'd0;
      phase_q     <= PH_SEARCH;
      port_acc_q  <= '0;
      port_nz_q   <= 1'b0;
      type_acc_q  <= '0;
      type_nz_q   <= 1'b0;
      held_port_q <= '0;
      held_type_q <= '0;
      held_rate_q <= '0;
    end else begin
      match_q     <= match_d;
      phase_q     <= phase_d;
      port_acc_q  <= port_acc_d;
      port_nz_q   <= port_nz_d;
      type_acc_q  <= type_acc_d;
      type_nz_q   <= type_nz_d;
      held_port_q <= held_port_d;
      held_type_q <= held_type_d;
      held_rate_q <= held_rate_d;
    end
  end

  a_packet_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i.fire && step_i.item.last_byte) |=>
      (phase_q == PH_SEARCH && match_q == 3'd0 && !port_nz_q && !type_nz_q))
    else $error("per-packet state not cleared after last byte");

  a_rate_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_rate_q == 13'd0) || (held_rate_q == RATE_OK))
    else $error("held rate outside its two values");

  a_ok_updates_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item.status == STATUS_OK) |=>
      (held_rate_q == RATE_OK && held_port_q == $past(res_o.item.media_port)))
    else $error("good packet did not update held values");

  a_err_keeps_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item.status == STATUS_FMT_ERR) |=>
      ($stable(held_port_q) && $stable(held_type_q) && $stable(held_rate_q)))
    else $error("format error changed held values");

endmodule

/* hdl/sdpaml_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpaml_out_stage
// Result register. Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module sdpaml_out_stage
  import sdpaml_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_t      res_i,
  output logic      out_full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  assign out_full_o  = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    if (res_i.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      out_item_q <= res_i.item;
    end
  end

endmodule

/* hdl/sdp_audio_media_line_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_audio_media_line_parser_unit
// Finds the first audio media line of an SDP packet and reports its port
// and first payload type.
// ----------------------------------------------------------------------------
// Input channel: one packet byte per request (in_item_i), the last byte of a
// packet flagged by last_byte. Output channel: one result per packet, given
// for its last byte: status, held audio port, payload type and sample rate.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low.
// Throughput is one byte per cycle while in_stall_o is low: a byte is taken
// into the input register and parsed from it there; if it is a last byte,
// its result is loaded into the output register, which then drives
// out_valid_o and out_item_o.
// A stalled result holds in the output register; non-last bytes keep
// flowing, and only a last byte in the input register waits for room, which
// raises in_stall_o. Reset clears the parse state, the held port, type and
// rate (to zero) and empties both registers.
// ----------------------------------------------------------------------------
module sdp_audio_media_line_parser_unit
  import sdpaml_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  step_t step;
  res_t  res;
  logic  out_full;

  sdpaml_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_full_i (out_full),
    .step_o     (step)
  );

  sdpaml_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (res)
  );

  sdpaml_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_full_o  (out_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
